>>> sv/mag8_pkg.sv
// ----------------------------------------------------------------------------
// mag8_pkg
// Shared types and constants for the eight-share masked AND gadget.
// ----------------------------------------------------------------------------
package mag8_pkg;

    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // Shift-line positions seen by the share datapath: current lane, then
    // lanes k-1 .. k-4 (the line rotates so the current lane sits at 0).
    localparam int NUM_TAPS = 5;
    localparam logic [LANE_W-1:0] TAP_IDX [NUM_TAPS] = '{3'd0, 3'd7, 3'd6, 3'd5, 3'd4};

    localparam logic [LANE_W-1:0] LAST_LANE = 3'(LANES - 1);
    localparam logic [LANE_W-1:0] FIRST_LANE = '0;

    // Every fourth lane gets no extra mask word.
    localparam logic [1:0] NO_EXTRA_SLOT = 2'd3;

    typedef struct packed {
        logic shift;     // advance the shift lines by one lane
        logic load;      // shift in a new lane from the input port
        logic first;     // the loaded lane is lane 0: capture extra words
    } mag8_store_ctl_t;

endpackage

>>> sv/mag8_lane_store.sv
// ----------------------------------------------------------------------------
// mag8_lane_store
// Eight-lane shift lines for the x, y, r, rtag and refresh shares plus the
// three extra mask words. Loads shift in at the top; during emission the
// lines rotate so the current lane always sits at position 0.
// ----------------------------------------------------------------------------
module mag8_lane_store
    import mag8_pkg::*;
#(
    parameter int WORD_WIDTH = 64
)
(
    input  logic                  clk,
    input  mag8_store_ctl_t       ctl,
    input  logic [WORD_WIDTH-1:0] x_in,
    input  logic [WORD_WIDTH-1:0] y_in,
    input  logic [WORD_WIDTH-1:0] r_in,
    input  logic [WORD_WIDTH-1:0] rtag_in,
    input  logic [WORD_WIDTH-1:0] refr_in,
    input  logic [WORD_WIDTH-1:0] e0_in,
    input  logic [WORD_WIDTH-1:0] e1_in,
    input  logic [WORD_WIDTH-1:0] e2_in,
    output logic [WORD_WIDTH-1:0] x_tap    [NUM_TAPS-1],
    output logic [WORD_WIDTH-1:0] y_tap    [NUM_TAPS],
    output logic [WORD_WIDTH-1:0] refr_tap [NUM_TAPS],
    output logic [WORD_WIDTH-1:0] r_tap    [2],
    output logic [WORD_WIDTH-1:0] rtag_tap [2],
    output logic [WORD_WIDTH-1:0] extra    [3]
);

    logic [WORD_WIDTH-1:0] x_reg    [LANES];
    logic [WORD_WIDTH-1:0] y_reg    [LANES];
    logic [WORD_WIDTH-1:0] r_reg    [LANES];
    logic [WORD_WIDTH-1:0] rtag_reg [LANES];
    logic [WORD_WIDTH-1:0] refr_reg [LANES];
    logic [WORD_WIDTH-1:0] extra_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int i = 0; i < LANES - 1; i++)
            begin
                x_reg[i]    <= x_reg[i+1];
                y_reg[i]    <= y_reg[i+1];
                r_reg[i]    <= r_reg[i+1];
                rtag_reg[i] <= rtag_reg[i+1];
                refr_reg[i] <= refr_reg[i+1];
            end
            x_reg[LANES-1]    <= ctl.load ? x_in    : x_reg[0];
            y_reg[LANES-1]    <= ctl.load ? y_in    : y_reg[0];
            r_reg[LANES-1]    <= ctl.load ? r_in    : r_reg[0];
            rtag_reg[LANES-1] <= ctl.load ? rtag_in : rtag_reg[0];
            refr_reg[LANES-1] <= ctl.load ? refr_in : refr_reg[0];
        end
        if (ctl.load && ctl.first)
        begin
            extra_reg[0] <= e0_in;
            extra_reg[1] <= e1_in;
            extra_reg[2] <= e2_in;
        end
    end

    always_comb
    begin
        for (int d = 0; d < NUM_TAPS; d++)
        begin
            y_tap[d]    = y_reg[TAP_IDX[d]];
            refr_tap[d] = refr_reg[TAP_IDX[d]];
        end
        for (int d = 0; d < NUM_TAPS - 1; d++)
        begin
            x_tap[d] = x_reg[TAP_IDX[d]];
        end
        for (int d = 0; d < 2; d++)
        begin
            r_tap[d]    = r_reg[TAP_IDX[d]];
            rtag_tap[d] = rtag_reg[TAP_IDX[d]];
        end
        for (int i = 0; i < 3; i++)
        begin
            extra[i] = extra_reg[i];
        end
    end

endmodule

>>> sv/mag8_share_calc.sv
// ----------------------------------------------------------------------------
// mag8_share_calc
// One output share: refresh of x for lanes k..k-3, cross products with y and
// the r / rtag masks, all from fixed shift-line taps.
// ----------------------------------------------------------------------------
module mag8_share_calc
    import mag8_pkg::*;
#(
    parameter int WORD_WIDTH = 64
)
(
    input  logic [LANE_W-1:0]     lane,
    input  logic [WORD_WIDTH-1:0] x_tap    [NUM_TAPS-1],
    input  logic [WORD_WIDTH-1:0] y_tap    [NUM_TAPS],
    input  logic [WORD_WIDTH-1:0] refr_tap [NUM_TAPS],
    input  logic [WORD_WIDTH-1:0] r_tap    [2],
    input  logic [WORD_WIDTH-1:0] rtag_tap [2],
    input  logic [WORD_WIDTH-1:0] extra    [3],
    output logic [WORD_WIDTH-1:0] z
);

    logic [WORD_WIDTH-1:0] xr  [NUM_TAPS-1];
    logic [WORD_WIDTH-1:0] e_w [NUM_TAPS-1];
    logic [LANE_W-1:0]     src [NUM_TAPS-1];

    always_comb
    begin
        for (int d = 0; d < NUM_TAPS - 1; d++)
        begin
            src[d] = lane - LANE_W'(d);
            // extra word pattern repeats every four lanes
            if (src[d][1:0] == NO_EXTRA_SLOT)
            begin
                e_w[d] = '0;
            end
            else
            begin
                e_w[d] = extra[src[d][1:0]];
            end
            xr[d] = x_tap[d] ^ refr_tap[d] ^ refr_tap[d+1] ^ e_w[d];
        end

        z = r_tap[0] ^ r_tap[1] ^ rtag_tap[0] ^ rtag_tap[1];
        for (int d = 0; d < NUM_TAPS; d++)
        begin
            z = z ^ (xr[0] & y_tap[d]);
        end
        for (int d = 1; d < NUM_TAPS - 1; d++)
        begin
            z = z ^ (xr[d] & y_tap[0]);
        end
    end

endmodule

>>> sv/masked_and_gadget_8_share.sv
// ----------------------------------------------------------------------------
// masked_and_gadget_8_share
// Eight-share masked AND of WORD_WIDTH-bit words with x refresh.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | x_share y_share rand_r rand_rtag
//          |                      | rand_refresh extra_zero extra_one extra_two
//  out     | out_valid / out_ready| z_share last
//
//  Eight load transfers, one per cycle while in_valid is high, fill the lane
//  shift lines; then eight shares leave one per cycle from the output register
//  while out_ready allows, all computed by the single shared share datapath.
//  in_ready is low while the batch drains; the next batch may start loading
//  while the final share still waits in the output register.
//  A stalled out_ready holds the output register and pauses the drain.
//  Reset clears the lane counter, phase and output valid; stores are not reset.
// ----------------------------------------------------------------------------
module masked_and_gadget_8_share
    import mag8_pkg::*;
#(
    parameter int WORD_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_WIDTH-1:0] x_share,
    input  logic [WORD_WIDTH-1:0] y_share,
    input  logic [WORD_WIDTH-1:0] rand_r,
    input  logic [WORD_WIDTH-1:0] rand_rtag,
    input  logic [WORD_WIDTH-1:0] rand_refresh,
    input  logic [WORD_WIDTH-1:0] extra_zero,
    input  logic [WORD_WIDTH-1:0] extra_one,
    input  logic [WORD_WIDTH-1:0] extra_two,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_WIDTH-1:0] z_share,
    output logic                  last
);

    localparam logic PH_LOAD = 1'b0;
    localparam logic PH_EMIT = 1'b1;

    logic                  phase_reg, phase_next;
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_WIDTH-1:0] z_reg;
    logic                  last_reg;

    logic                  in_xfer;
    logic                  emit_fire;
    mag8_store_ctl_t       ctl;
    logic [WORD_WIDTH-1:0] z_calc;

    logic [WORD_WIDTH-1:0] x_tap    [NUM_TAPS-1];
    logic [WORD_WIDTH-1:0] y_tap    [NUM_TAPS];
    logic [WORD_WIDTH-1:0] refr_tap [NUM_TAPS];
    logic [WORD_WIDTH-1:0] r_tap    [2];
    logic [WORD_WIDTH-1:0] rtag_tap [2];
    logic [WORD_WIDTH-1:0] extra    [3];

    assign in_ready  = (phase_reg == PH_LOAD);
    assign in_xfer   = in_valid && in_ready;
    assign emit_fire = (phase_reg == PH_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ctl.load  = in_xfer;
        ctl.shift = in_xfer || emit_fire;
        ctl.first = (lane_reg == FIRST_LANE);
    end

    mag8_lane_store #(.WORD_WIDTH(WORD_WIDTH)) u_store (
        .clk      (clk),
        .ctl      (ctl),
        .x_in     (x_share),
        .y_in     (y_share),
        .r_in     (rand_r),
        .rtag_in  (rand_rtag),
        .refr_in  (rand_refresh),
        .e0_in    (extra_zero),
        .e1_in    (extra_one),
        .e2_in    (extra_two),
        .x_tap    (x_tap),
        .y_tap    (y_tap),
        .refr_tap (refr_tap),
        .r_tap    (r_tap),
        .rtag_tap (rtag_tap),
        .extra    (extra)
    );

    mag8_share_calc #(.WORD_WIDTH(WORD_WIDTH)) u_calc (
        .lane     (lane_reg),
        .x_tap    (x_tap),
        .y_tap    (y_tap),
        .refr_tap (refr_tap),
        .r_tap    (r_tap),
        .rtag_tap (rtag_tap),
        .extra    (extra),
        .z        (z_calc)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg;
        if (in_xfer || emit_fire)
        begin
            lane_next = lane_reg + 1'b1;
            if (lane_reg == LAST_LANE)
            begin
                phase_next = in_xfer ? PH_EMIT : PH_LOAD;
            end
        end
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LOAD;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            z_reg    <= z_calc;
            last_reg <= (lane_reg == LAST_LANE);
        end
    end

    assign out_valid = out_valid_reg;
    assign z_share   = z_reg;
    assign last      = last_reg;

endmodule

>>> sv/mag8_checker.sv
// ----------------------------------------------------------------------------
// mag8_checker
// Port-level checks on load / drain sequencing of the masked AND gadget.
// ----------------------------------------------------------------------------
module mag8_checker
#(
    parameter int WORD_WIDTH = 64
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [WORD_WIDTH-1:0] z_share,
    input logic                  last
);

    // stalled share holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(z_share) && $stable(last))
        else $error("output share changed while stalled");

    // no loads while a batch still drains
    a_no_load_mid_batch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready during share drain");

    // a full batch loaded behind a waiting final share starts draining at once
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last && !in_ready |=> out_valid && !last)
        else $error("queued batch did not start draining after final share");

    // a load transfer only overlaps a waiting final share
    a_load_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || last)
        else $error("load transfer while a non-final share is pending");

endmodule

bind masked_and_gadget_8_share mag8_checker #(.WORD_WIDTH(WORD_WIDTH)) u_mag8_checker (.*);
